// File: rtl/ktrk_pkg.sv
package ktrk_pkg;

    localparam int MAX_KEYS_DEF  = 64;
    localparam int FRAME_W       = 16;
    localparam int POS_W         = 32;
    localparam int HEAD_W        = 16;
    localparam int ELAPSED_W     = 24;
    localparam int ANIM_W        = 17;
    localparam int KEY_COUNT_W   = 7;
    localparam int PHASE_W       = 16;
    localparam int KEY_INDEX_W   = 6;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 16;
    localparam int BIAS_W        = 17;
    localparam int QUOT_W        = 16;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE     = 1'b1;

    typedef struct packed {
        logic        [FRAME_W-1:0] frame;
        logic signed [POS_W-1:0]   x;
        logic signed [POS_W-1:0]   y;
        logic signed [HEAD_W-1:0]  heading;
    } ktrk_key_t;

    typedef enum logic [1:0] {
        RD_LAST = 2'd0,
        RD_ZERO = 2'd1,
        RD_ONE  = 2'd2,
        RD_NEXT = 2'd3
    } ktrk_rd_t;

    typedef struct packed {
        logic     take;
        ktrk_rd_t rd_sel;
        logic     one_cap;
        logic     len_cap;
        logic     first_cap;
        logic     search_adv;
        logic     hit_cap;
        logic     bias_start;
        logic     mul_x;
        logic     mul_y;
        logic     mul_h;
        logic     mul_end;
        logic     out_load;
    } ktrk_cmd_t;

    typedef struct packed {
        logic n_one;
        logic search_stop;
        logic bias_direct;
        logic div_done;
    } ktrk_status_t;

endpackage

// File: rtl/ktrk_div.sv
module ktrk_div
    import ktrk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [23:0]           num,
    input  logic [QUOT_W-1:0]     span,
    output logic                  done,
    output logic [QUOT_W-1:0]     quot
);

    localparam int CNT_W = $clog2(QUOT_W);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [QUOT_W-1:0] rem_reg, rem_next;
    logic [QUOT_W-1:0] dvd_reg, dvd_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [QUOT_W-1:0] span_reg, span_next;
    logic [QUOT_W:0]   trial;
    logic              qbit;

    // The caller guarantees num < span * 256, so the quotient fits in 16 bits
    // and the upper part of the shifted dividend is already below the divisor.
    assign trial = {rem_reg, dvd_reg[QUOT_W-1]};
    assign qbit  = (trial >= {1'b0, span_reg});
    assign done  = busy_reg && (cnt_reg == CNT_W'(QUOT_W - 1));
    assign quot  = {quot_reg[QUOT_W-2:0], qbit};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        span_next = span_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = num[23:8];
            dvd_next  = {num[7:0], 8'b0};
            quot_next = '0;
            span_next = span;
        end
        else if (busy_reg)
        begin
            rem_next  = qbit ? QUOT_W'(trial - {1'b0, span_reg}) : trial[QUOT_W-1:0];
            dvd_next  = {dvd_reg[QUOT_W-2:0], 1'b0};
            quot_next = quot;
            cnt_next  = cnt_reg + CNT_W'(1);
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
        span_reg <= span_next;
    end

endmodule

// File: rtl/ktrk_dp.sv
module ktrk_dp
    import ktrk_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ktrk_cmd_t                   cmd,
    output ktrk_status_t                status,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        command,
    input  logic [KEY_INDEX_W-1:0]      key_index,
    input  logic [FRAME_W-1:0]          key_frame,
    input  logic signed [POS_W-1:0]     key_x,
    input  logic signed [POS_W-1:0]     key_y,
    input  logic signed [HEAD_W-1:0]    key_heading,
    input  logic signed [ELAPSED_W-1:0] elapsed_frame,
    output logic signed [POS_W-1:0]     pos_x,
    output logic signed [POS_W-1:0]     pos_y,
    output logic signed [HEAD_W-1:0]    heading,
    output logic [ANIM_W-1:0]           anim_frame
);

    localparam int KW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int IW  = (KW > KEY_INDEX_W) ? KW : KEY_INDEX_W;
    localparam int NW  = ($clog2(MAX_KEYS + 1) > KEY_COUNT_W) ? $clog2(MAX_KEYS + 1)
                                                               : KEY_COUNT_W;
    localparam logic [IW:0]   MAX_IDX_V = (IW + 1)'(MAX_KEYS);
    localparam logic [NW-1:0] MAX_N_V   = NW'(MAX_KEYS);
    localparam int SUM_W  = POS_W + 3;
    localparam int DIFF_W = POS_W + 1;
    localparam int PROD_W = DIFF_W + BIAS_W + 1;

    ktrk_key_t mem [MAX_KEYS];
    ktrk_key_t rd_data_reg;
    ktrk_key_t a_reg, b_reg;
    ktrk_key_t wr_key;

    logic [KEY_COUNT_W-1:0]      key_count_reg;
    logic [PHASE_W-1:0]          phase_reg;
    logic signed [ELAPSED_W-1:0] el_reg;
    logic [ANIM_W-1:0]           anim_reg;
    logic [23:0]                 t_reg, t_next;
    logic [KW-1:0]               hi_reg;
    logic [BIAS_W-1:0]           bias_reg;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic signed [POS_W-1:0]     px_reg, py_reg, out_x_reg, out_y_reg;
    logic signed [HEAD_W-1:0]    ph_reg, out_h_reg;
    logic [ANIM_W-1:0]           out_anim_reg;

    logic [IW-1:0]       idx_ext;
    logic                wr_en;
    logic [NW-1:0]       n_raw, n_sat, n_m1;
    logic [KW-1:0]       n_last;
    logic [KW-1:0]       rd_addr;
    logic [FRAME_W-1:0]  len_frames;
    logic [23:0]         len_t;
    logic [16:0]         span;
    logic [24:0]         num;
    logic                span_pos, num_pos, num_ge;
    logic                div_done;
    logic [QUOT_W-1:0]   quot;
    logic [15:0]         whole;
    logic signed [DIFF_W-1:0]   mul_a;
    logic signed [BIAS_W:0]     bias_s;
    logic signed [PROD_W-1:0]   prod_sh;
    logic [SUM_W-1:0]    add_a, add_sum;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= KEY_COUNT_W'(1);
            phase_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY_COUNT: key_count_reg <= cfg_data[KEY_COUNT_W-1:0];
                CFG_PHASE:     phase_reg     <= cfg_data[PHASE_W-1:0];
                default:       phase_reg     <= phase_reg;
            endcase
        end
    end

    // A zero key count behaves as one key; counts above the table depth saturate.
    assign n_raw  = NW'(key_count_reg);
    assign n_sat  = (n_raw == '0) ? NW'(1) : ((n_raw > MAX_N_V) ? MAX_N_V : n_raw);
    assign n_m1   = n_sat - NW'(1);
    assign n_last = n_m1[KW-1:0];

    // Key table.
    assign idx_ext = IW'(key_index);
    assign wr_en   = cmd.take && (command == CMD_WRITE) && ({1'b0, idx_ext} < MAX_IDX_V);
    assign wr_key  = '{frame: key_frame, x: key_x, y: key_y, heading: key_heading};

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_LAST: rd_addr = n_last;
            RD_ZERO: rd_addr = '0;
            RD_ONE:  rd_addr = KW'(1);
            RD_NEXT: rd_addr = hi_reg + KW'(1);
            default: rd_addr = n_last;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[idx_ext[KW-1:0]] <= wr_key;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Sample time clamped to the path length.
    assign len_frames = (rd_data_reg.frame == '0) ? FRAME_W'(1) : rd_data_reg.frame;
    assign len_t      = {len_frames, 8'b0};

    always_comb
    begin
        if (el_reg[ELAPSED_W-1])
        begin
            t_next = '0;
        end
        else if ({1'b0, el_reg[ELAPSED_W-2:0]} > len_t)
        begin
            t_next = len_t;
        end
        else
        begin
            t_next = el_reg[ELAPSED_W-1:0];
        end
    end

    // Whole frames come straight from the request, since they are registered as it is taken.
    assign whole = elapsed_frame[ELAPSED_W-1] ? 16'd0 : elapsed_frame[ELAPSED_W-1:8];

    // Bias of the segment between keys a and b.
    assign span     = {1'b0, b_reg.frame} - {1'b0, a_reg.frame};
    assign num      = {1'b0, t_reg} - {1'b0, a_reg.frame, 8'b0};
    assign span_pos = !span[16] && (span != '0);
    assign num_pos  = !num[24] && (num != '0);
    assign num_ge   = (num[23:0] >= {span[15:0], 8'b0});

    ktrk_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.bias_start && span_pos && num_pos && !num_ge),
        .num   (num[23:0]),
        .span  (span[15:0]),
        .done  (div_done),
        .quot  (quot)
    );

    // One shared multiplier; each product is registered before its add.
    always_comb
    begin
        priority if (cmd.mul_x)
        begin
            mul_a = {b_reg.x[POS_W-1], b_reg.x} - {a_reg.x[POS_W-1], a_reg.x};
        end
        else if (cmd.mul_y)
        begin
            mul_a = {b_reg.y[POS_W-1], b_reg.y} - {a_reg.y[POS_W-1], a_reg.y};
        end
        else
        begin
            mul_a = DIFF_W'({{(DIFF_W-HEAD_W){b_reg.heading[HEAD_W-1]}}, b_reg.heading})
                  - DIFF_W'({{(DIFF_W-HEAD_W){a_reg.heading[HEAD_W-1]}}, a_reg.heading});
        end
    end

    assign bias_s    = {1'b0, bias_reg};
    assign prod_next = mul_a * bias_s;
    assign prod_sh   = prod_reg >>> 16;

    always_comb
    begin
        priority if (cmd.mul_y)
        begin
            add_a = {{(SUM_W-POS_W){a_reg.x[POS_W-1]}}, a_reg.x};
        end
        else if (cmd.mul_h)
        begin
            add_a = {{(SUM_W-POS_W){a_reg.y[POS_W-1]}}, a_reg.y};
        end
        else
        begin
            add_a = {{(SUM_W-HEAD_W){a_reg.heading[HEAD_W-1]}}, a_reg.heading};
        end
    end

    assign add_sum = add_a + prod_sh[SUM_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            el_reg   <= elapsed_frame;
            anim_reg <= {1'b0, phase_reg} + {1'b0, whole};
        end
        if (cmd.len_cap)
        begin
            t_reg <= t_next;
        end
        if (cmd.first_cap)
        begin
            a_reg  <= rd_data_reg;
            hi_reg <= KW'(1);
        end
        if (cmd.search_adv)
        begin
            a_reg  <= rd_data_reg;
            hi_reg <= hi_reg + KW'(1);
        end
        if (cmd.hit_cap)
        begin
            b_reg <= rd_data_reg;
        end
        if (cmd.bias_start)
        begin
            bias_reg <= (span_pos && num_pos && num_ge) ? BIAS_W'(65536) : '0;
        end
        if (div_done)
        begin
            bias_reg <= {1'b0, quot};
        end
        if (cmd.mul_x || cmd.mul_y || cmd.mul_h)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.mul_y)
        begin
            px_reg <= add_sum[POS_W-1:0];
        end
        if (cmd.mul_h)
        begin
            py_reg <= add_sum[POS_W-1:0];
        end
        if (cmd.mul_end)
        begin
            ph_reg <= add_sum[HEAD_W-1:0];
        end
        if (cmd.one_cap)
        begin
            px_reg <= rd_data_reg.x;
            py_reg <= rd_data_reg.y;
            ph_reg <= rd_data_reg.heading;
        end
        if (cmd.out_load)
        begin
            out_x_reg    <= px_reg;
            out_y_reg    <= py_reg;
            out_h_reg    <= ph_reg;
            out_anim_reg <= anim_reg;
        end
    end

    assign status.n_one       = (n_sat == NW'(1));
    assign status.search_stop = (hi_reg == n_last) || ({rd_data_reg.frame, 8'b0} >= t_reg);
    assign status.bias_direct = !(span_pos && num_pos && !num_ge);
    assign status.div_done    = div_done;

    assign pos_x      = out_x_reg;
    assign pos_y      = out_y_reg;
    assign heading    = out_h_reg;
    assign anim_frame = out_anim_reg;

endmodule

// File: rtl/ktrk_ctrl.sv
module ktrk_ctrl
    import ktrk_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         command,
    input  logic         out_stall,
    output logic         in_stall,
    output logic         out_valid,
    output ktrk_cmd_t    cmd,
    input  ktrk_status_t status
);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_LEN    = 11'b00000000010,
        ST_FIRST  = 11'b00000000100,
        ST_SEARCH = 11'b00000001000,
        ST_BIAS   = 11'b00000010000,
        ST_DIV    = 11'b00000100000,
        ST_MULX   = 11'b00001000000,
        ST_MULY   = 11'b00010000000,
        ST_MULH   = 11'b00100000000,
        ST_MULE   = 11'b01000000000,
        ST_DONE   = 11'b10000000000
    } ktrk_state_t;

    ktrk_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_LAST;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (command == CMD_SAMPLE)
                    begin
                        state_next = ST_LEN;
                    end
                end
            end
            ST_LEN:
            begin
                cmd.rd_sel = RD_ZERO;
                if (status.n_one)
                begin
                    cmd.one_cap = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cmd.len_cap = 1'b1;
                    state_next  = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                cmd.rd_sel    = RD_ONE;
                cmd.first_cap = 1'b1;
                state_next    = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                // Memory read data arrives in the cycle after its address, so the next
                // key is fetched while the current one is compared.
                cmd.rd_sel = RD_NEXT;
                if (status.search_stop)
                begin
                    cmd.hit_cap = 1'b1;
                    state_next  = ST_BIAS;
                end
                else
                begin
                    cmd.search_adv = 1'b1;
                end
            end
            ST_BIAS:
            begin
                cmd.bias_start = 1'b1;
                state_next     = status.bias_direct ? ST_MULX : ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_MULX;
                end
            end
            ST_MULX:
            begin
                cmd.mul_x  = 1'b1;
                state_next = ST_MULY;
            end
            ST_MULY:
            begin
                cmd.mul_y  = 1'b1;
                state_next = ST_MULH;
            end
            ST_MULH:
            begin
                cmd.mul_h  = 1'b1;
                state_next = ST_MULE;
            end
            ST_MULE:
            begin
                cmd.mul_end = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/keyframe_track_sampler.sv
// Piecewise linear keyframe track sampler. A write request stores one key
// (frame, x, y, yaw) in a key table with one write and one read port and
// does not stall the input. A sample request stalls the input while it is
// worked on; with more than one key in use it searches for the segment,
// sets its bias, with the 16-step divider where needed, and then
// interpolates x, y and yaw. Its run time is set by the segment search, which
// reads one key per cycle through the table's read port, by the bit-serial
// bias divider, and by one multiplier shared by x, y and yaw. A finished
// result waits in an output register, so the next request is taken while it
// is still stalled. Configuration is taken at any time (cfg_ready stays
// high) but must only be written while the block is idle.
module keyframe_track_sampler
    import ktrk_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        command,
    input  logic [KEY_INDEX_W-1:0]      key_index,
    input  logic [FRAME_W-1:0]          key_frame,
    input  logic signed [POS_W-1:0]     key_x,
    input  logic signed [POS_W-1:0]     key_y,
    input  logic signed [HEAD_W-1:0]    key_heading,
    input  logic signed [ELAPSED_W-1:0] elapsed_frame,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [POS_W-1:0]     pos_x,
    output logic signed [POS_W-1:0]     pos_y,
    output logic signed [HEAD_W-1:0]    heading,
    output logic [ANIM_W-1:0]           anim_frame,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    ktrk_cmd_t    cmd;
    ktrk_status_t status;

    assign cfg_ready = 1'b1;

    ktrk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .command   (command),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd),
        .status    (status)
    );

    ktrk_dp #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (command),
        .key_index     (key_index),
        .key_frame     (key_frame),
        .key_x         (key_x),
        .key_y         (key_y),
        .key_heading   (key_heading),
        .elapsed_frame (elapsed_frame),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .heading       (heading),
        .anim_frame    (anim_frame)
    );

    // A sample request keeps the input stalled while it is worked on.
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && command == CMD_SAMPLE) |=> in_stall)
        else $error("sample request did not start a sequence");

    // A write request finishes in the cycle it is taken.
    a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && command == CMD_WRITE) |=> !in_stall)
        else $error("write request held the input");

    // A result is never loaded over one that is still stalled.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("output register overwritten while stalled");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("loaded result not presented");

endmodule
